// File: rtl/core/assert_macros.svh
// Assertion macros shared by the contact block modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset
`define SSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define SSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/core/ssc_pkg.sv
// Shared types and constants of the sphere contact block
`default_nettype none
package ssc_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_AW        = 2;

   // Classification of one pair by the front part
   typedef enum logic [2:0] {
      KIND_MISS    = 3'b001,
      KIND_SAME    = 3'b010,
      KIND_GENERAL = 3'b100
   } kind_type;
endpackage
`default_nettype wire

// File: rtl/core/sphere_sphere_contact.sv
// Top level of the sphere-versus-sphere contact block
`default_nettype none
// Sphere contact test. One candidate pair is taken per cycle and one contact
// word comes back per pair, in order. A front pipeline of two stages forms the
// centre differences, the squared distance and the hit class; a four-entry
// queue parts it from a back pipeline of COORD_WIDTH+FRAC_BITS+3 stages that
// takes the square root one root bit per stage, divides one normal bit per
// stage and forms the contact point. A word comes back after the two front
// stages, the queue and the back stages. Throughput is one word per cycle
// while the result side takes them; a stalled result side holds the back pipe,
// then the queue and then the front fill up before req_tready drops.
module sphere_sphere_contact #(
   parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ssc_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // first_x, first_y, first_z, first_radius, second_x, second_y, second_z,
   // second_radius, from the lowest bit up, zero filled
   input  wire logic [((8*COORD_WIDTH-4+7)/8)*8-1:0] req_tdata,
   input  wire logic req_tuser,   // result_is_first
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // normal_x, normal_y, normal_z, point_x, point_y, point_z, overlap, zero filled
   output logic [((3*(FRAC_BITS+2)+4*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0] rsp_tuser   // hit, penetrates_other
);
   import ssc_pkg::*;
   localparam int W  = COORD_WIDTH;
   localparam int NW = FRAC_BITS + 2;
   localparam int RW = W - 2;
   localparam int OW = ((3*NW + 4*W + 7) / 8) * 8;

   logic f_valid, f_ready;
   kind_type f_kind;
   logic [2*W+1:0] f_d2;
   logic [W:0] f_dx, f_dy, f_dz;
   logic [W-1:0] f_sum, f_c1x, f_c1y, f_c1z, f_c2x, f_c2y, f_c2z;
   logic [RW-1:0] f_r1, f_r2;
   logic f_first;

   ssc_front #(.COORD_WIDTH(W)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .c1_x(req_tdata[W-1:0]), .c1_y(req_tdata[2*W-1:W]), .c1_z(req_tdata[3*W-1:2*W]),
      .r1(req_tdata[3*W+RW-1:3*W]),
      .c2_x(req_tdata[3*W+RW+W-1:3*W+RW]), .c2_y(req_tdata[3*W+RW+2*W-1:3*W+RW+W]),
      .c2_z(req_tdata[6*W+RW-1:5*W+RW]), .r2(req_tdata[6*W+2*RW-1:6*W+RW]),
      .is_first(req_tuser),
      .out_valid(f_valid), .out_ready(f_ready), .out_kind(f_kind), .out_d2(f_d2),
      .out_dx(f_dx), .out_dy(f_dy), .out_dz(f_dz), .out_sum(f_sum),
      .out_c2x(f_c2x), .out_c2y(f_c2y), .out_c2z(f_c2z),
      .out_c1x(f_c1x), .out_c1y(f_c1y), .out_c1z(f_c1z),
      .out_r1(f_r1), .out_r2(f_r2), .out_first(f_first)
   );

   localparam int QW = 3 + (2*W+2) + 3*(W+1) + 7*W + 2*RW + 1;
   logic [QW-1:0] q_in, q_out;
   logic q_valid, q_ready;
   assign q_in = {f_kind, f_d2, f_dx, f_dy, f_dz, f_sum, f_c1x, f_c1y, f_c1z,
                  f_c2x, f_c2y, f_c2z, f_r1, f_r2, f_first};

   ssc_queue #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready), .in_data(q_in),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_out)
   );

   kind_type b_kind;
   logic [2*W+1:0] b_d2;
   logic [W:0] b_dx, b_dy, b_dz;
   logic [W-1:0] b_sum, b_c1x, b_c1y, b_c1z, b_c2x, b_c2y, b_c2z;
   logic [RW-1:0] b_r1, b_r2;
   logic b_first;
   assign {b_kind, b_d2, b_dx, b_dy, b_dz, b_sum, b_c1x, b_c1y, b_c1z,
           b_c2x, b_c2y, b_c2z, b_r1, b_r2, b_first} = q_out;

   logic [NW-1:0] nx, ny, nz;
   logic [W-1:0] px, py, pz, ov;
   logic hit, pen;

   ssc_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_ready(q_ready),
      .in_kind(b_kind), .in_d2(b_d2), .in_dx(b_dx), .in_dy(b_dy), .in_dz(b_dz),
      .in_sum(b_sum), .in_c1x(b_c1x), .in_c1y(b_c1y), .in_c1z(b_c1z),
      .in_c2x(b_c2x), .in_c2y(b_c2y), .in_c2z(b_c2z), .in_r1(b_r1), .in_r2(b_r2),
      .in_first(b_first), .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_hit(hit), .out_nx(nx), .out_ny(ny), .out_nz(nz),
      .out_px(px), .out_py(py), .out_pz(pz), .out_ov(ov), .out_pen(pen)
   );

   assign rsp_tdata = OW'({ov, pz, py, px, nz, ny, nx});
   assign rsp_tuser = {pen, hit};
endmodule
`default_nettype wire

// File: rtl/core/ssc_front.sv
// Front part: centre differences, squared distance and hit classification
`default_nettype none
`include "assert_macros.svh"
module ssc_front #(
   parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [COORD_WIDTH-1:0] c1_x, c1_y, c1_z,
   input  wire logic [COORD_WIDTH-3:0] r1,
   input  wire logic [COORD_WIDTH-1:0] c2_x, c2_y, c2_z,
   input  wire logic [COORD_WIDTH-3:0] r2,
   input  wire logic                   is_first,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output ssc_pkg::kind_type           out_kind,
   output logic [2*COORD_WIDTH+1:0]    out_d2,
   output logic [COORD_WIDTH:0]        out_dx, out_dy, out_dz,
   output logic [COORD_WIDTH-1:0]      out_sum,
   output logic [COORD_WIDTH-1:0]      out_c2x, out_c2y, out_c2z, out_c1x, out_c1y, out_c1z,
   output logic [COORD_WIDTH-3:0]      out_r1, out_r2,
   output logic                        out_first
);
   import ssc_pkg::*;
   localparam int W  = COORD_WIDTH;
   localparam int DW = W + 1;
   localparam int SW = 2 * W + 2;

   // stage 1: differences and squares
   logic              s1_valid_ff, s1_valid_in;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic [W-1:0]      c1x_ff, c1y_ff, c1z_ff, c2x_ff, c2y_ff, c2z_ff;
   logic [W-3:0]      r1_ff, r2_ff;
   logic              first_ff;
   logic              far_ff;
   logic [2*W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   // stage 2: summed and compared
   logic              s2_valid_ff, s2_valid_in;
   logic              s1_adv, s2_adv;

   logic signed [DW-1:0] dx_c, dy_c, dz_c;
   logic [DW-1:0] ax_c, ay_c, az_c;
   logic far_c;

   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   always_comb begin
      dx_c = DW'($signed(c1_x)) - DW'($signed(c2_x));
      dy_c = DW'($signed(c1_y)) - DW'($signed(c2_y));
      dz_c = DW'($signed(c1_z)) - DW'($signed(c2_z));
      ax_c = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
      ay_c = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
      az_c = dz_c[DW-1] ? DW'(-dz_c) : DW'(dz_c);
      far_c = ax_c[W-1] | ay_c[W-1] | az_c[W-1] | ax_c[W] | ay_c[W] | az_c[W];
   end

   assign s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   // capture stage 1 payload
   always_ff @(posedge clock) begin
      if (s1_adv && in_valid) begin
         dx_ff <= dx_c; dy_ff <= dy_c; dz_ff <= dz_c;
         sqx_ff <= (2*W)'(ax_c[W-2:0] * ax_c[W-2:0]);
         sqy_ff <= (2*W)'(ay_c[W-2:0] * ay_c[W-2:0]);
         sqz_ff <= (2*W)'(az_c[W-2:0] * az_c[W-2:0]);
         far_ff <= far_c;
         c1x_ff <= c1_x; c1y_ff <= c1_y; c1z_ff <= c1_z;
         c2x_ff <= c2_x; c2y_ff <= c2_y; c2z_ff <= c2_z;
         r1_ff <= r1; r2_ff <= r2; first_ff <= is_first;
      end
   end

   // stage 2: sum squares, compare against the squared radius sum
   logic [SW-1:0] d2_c, sum2_c;
   logic [W-1:0]  sum_c;
   kind_type      kind_c;
   always_comb begin
      d2_c   = SW'(sqx_ff) + SW'(sqy_ff) + SW'(sqz_ff);
      sum_c  = W'(r1_ff) + W'(r2_ff);
      sum2_c = SW'(sum_c * sum_c);
      if (far_ff)                   kind_c = KIND_MISS;
      else if (d2_c == '0)          kind_c = KIND_SAME;
      else if (sum2_c > d2_c)       kind_c = KIND_GENERAL;
      else                          kind_c = KIND_MISS;
   end

   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s2_valid_in;
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         out_kind <= kind_c; out_d2 <= d2_c; out_sum <= sum_c;
         out_dx <= dx_ff; out_dy <= dy_ff; out_dz <= dz_ff;
         out_c1x <= c1x_ff; out_c1y <= c1y_ff; out_c1z <= c1z_ff;
         out_c2x <= c2x_ff; out_c2y <= c2y_ff; out_c2z <= c2z_ff;
         out_r1 <= r1_ff; out_r2 <= r2_ff; out_first <= first_ff;
      end
   end
   assign out_valid = s2_valid_ff;

   `SSC_ASSERT(a_front_hold, clock, reset, (s2_valid_ff && !out_ready) |=> s2_valid_ff, "front dropped a stalled word")
   `SSC_ASSERT(a_front_accept, clock, reset, (in_valid && in_ready) |=> s1_valid_ff, "front lost an accepted word")
endmodule
`default_nettype wire

// File: rtl/core/ssc_queue.sv
// Short queue between the front and back parts
`default_nettype none
`include "assert_macros.svh"
module ssc_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);
   import ssc_pkg::*;
   logic [WIDTH-1:0]      mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_AW:0]     cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   `SSC_ASSERT(a_q_bound, clock, reset, cnt_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH), "queue count overflow")
   `SSC_ASSERT(a_q_count, clock, reset, (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1, "queue count wrong")
endmodule
`default_nettype wire

// File: rtl/core/ssc_back.sv
// Back part: square root, normalize, contact point; one item per cycle unless held
`default_nettype none
`include "assert_macros.svh"
module ssc_back #(
   parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ssc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  ssc_pkg::kind_type           in_kind,
   input  wire logic [2*COORD_WIDTH+1:0] in_d2,
   input  wire logic [COORD_WIDTH:0]   in_dx, in_dy, in_dz,
   input  wire logic [COORD_WIDTH-1:0] in_sum,
   input  wire logic [COORD_WIDTH-1:0] in_c1x, in_c1y, in_c1z, in_c2x, in_c2y, in_c2z,
   input  wire logic [COORD_WIDTH-3:0] in_r1, in_r2,
   input  wire logic                   in_first,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic                        out_hit,
   output logic [FRAC_BITS+1:0]        out_nx, out_ny, out_nz,
   output logic [COORD_WIDTH-1:0]      out_px, out_py, out_pz,
   output logic [COORD_WIDTH-1:0]      out_ov,
   output logic                        out_pen
);
   import ssc_pkg::*;
   localparam int W   = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int NW  = F + 2;
   localparam int SW  = 2 * W + 2;
   localparam int RB  = W - 1;          // root bits
   localparam int QB  = F + 1;          // quotient bits per axis
   localparam int NS  = RB + QB + 3;    // pipeline depth
   localparam int PW  = W + NW + 2;

   typedef struct packed {
      kind_type          kind;
      logic [W:0]        dx, dy, dz;
      logic [W-1:0]      sum;
      logic [W-1:0]      c1x, c1y, c1z, c2x, c2y, c2z;
      logic [W-3:0]      r1, r2;
      logic              first;
   } meta_type;

   // one global advance for the whole pipe, held while the output word is stalled
   logic adv;
   logic [NS-1:0] v_ff;
   meta_type      m_ff   [NS];
   logic [SW-1:0] rem_ff [NS];   // square root remainder target
   logic [RB-1:0] root_ff[NS];
   logic [W:0]    qr_ff  [NS][3]; // divide remainders
   logic [QB:0]   q_ff   [NS][3];

   assign adv      = !out_valid || out_ready;
   assign in_ready = adv;

   meta_type m_c;
   always_comb begin
      m_c.kind = in_kind; m_c.dx = in_dx; m_c.dy = in_dy; m_c.dz = in_dz;
      m_c.sum = in_sum; m_c.c1x = in_c1x; m_c.c1y = in_c1y; m_c.c1z = in_c1z;
      m_c.c2x = in_c2x; m_c.c2y = in_c2y; m_c.c2z = in_c2z;
      m_c.r1 = in_r1; m_c.r2 = in_r2; m_c.first = in_first;
   end

   function automatic logic [W:0] mag(input logic [W:0] v);
      mag = v[W] ? (W+1)'(-v) : v;
   endfunction

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   // square root: one root bit per stage, then divide: one quotient bit per stage
   genvar g;
   generate
      for (g = 0; g < NS; g++) begin : g_st
         if (g == 0) begin : g_first
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[0] <= m_c; rem_ff[0] <= in_d2; root_ff[0] <= '0;
               end
            end
         end else if (g <= RB) begin : g_sqrt
            localparam int B = RB - g;
            logic [RB-1:0] t_c;
            logic [2*RB-1:0] tt_c;
            assign t_c  = root_ff[g-1] | (RB'(1) << B);
            assign tt_c = t_c * t_c;
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[g] <= m_ff[g-1]; rem_ff[g] <= rem_ff[g-1];
                  root_ff[g] <= (SW'(tt_c) > rem_ff[g-1]) ? root_ff[g-1] : t_c;
               end
            end
         end else if (g == RB + 1) begin : g_dinit
            logic [W:0] a_c [3];
            logic [W:0] dist_c;
            assign dist_c = (W+1)'(root_ff[g-1]);
            assign a_c[0] = mag(m_ff[g-1].dx);
            assign a_c[1] = mag(m_ff[g-1].dy);
            assign a_c[2] = mag(m_ff[g-1].dz);
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[g] <= m_ff[g-1]; rem_ff[g] <= rem_ff[g-1];
                  root_ff[g] <= root_ff[g-1];
                  for (int k = 0; k < 3; k++) begin
                     q_ff[g][k]  <= (QB+1)'(a_c[k] >= dist_c);
                     qr_ff[g][k] <= (a_c[k] >= dist_c) ? a_c[k] - dist_c : a_c[k];
                  end
               end
            end
         end else if (g <= RB + 1 + F) begin : g_div
            logic [W+1:0] dist_c;
            assign dist_c = (W+2)'(root_ff[g-1]);
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[g] <= m_ff[g-1]; rem_ff[g] <= rem_ff[g-1];
                  root_ff[g] <= root_ff[g-1];
                  for (int k = 0; k < 3; k++) begin
                     if ({qr_ff[g-1][k], 1'b0} >= dist_c) begin
                        qr_ff[g][k] <= (W+1)'({qr_ff[g-1][k], 1'b0} - dist_c);
                        q_ff[g][k]  <= {q_ff[g-1][k][QB-1:0], 1'b1};
                     end else begin
                        qr_ff[g][k] <= (W+1)'({qr_ff[g-1][k], 1'b0});
                        q_ff[g][k]  <= {q_ff[g-1][k][QB-1:0], 1'b0};
                     end
                  end
               end
            end
         end else begin : g_tail
            // pass-through stages; rounding is done below at the division end
            always_ff @(posedge clock) begin
               if (adv) begin
                  m_ff[g] <= m_ff[g-1]; rem_ff[g] <= rem_ff[g-1];
                  root_ff[g] <= root_ff[g-1]; qr_ff[g] <= qr_ff[g-1];
                  q_ff[g] <= q_ff[g-1];
               end
            end
         end
      end
   endgenerate

   // round the unit normal and form overlap and scale at the division end
   localparam int LD = RB + 1 + F;
   meta_type      md;
   logic [W:0]    dist_d;
   logic signed [NW-1:0] n_c [3];
   logic signed [W+1:0]  ov_c, s_c;
   logic [W:0] dd [3];
   always_comb begin
      md = m_ff[LD];
      dist_d = (W+1)'(root_ff[LD]);
      dd[0] = md.dx; dd[1] = md.dy; dd[2] = md.dz;
      for (int k = 0; k < 3; k++) begin
         logic [NW-1:0] m;
         m = NW'(q_ff[LD][k]) + NW'({qr_ff[LD][k], 1'b0} >= {1'b0, dist_d});
         n_c[k] = dd[k][W] ? NW'(-m) : NW'(m);
      end
      ov_c = (W+2)'(dist_d) - (W+2)'(md.sum);
      s_c  = (W+2)'(md.r2) + ov_c;
   end

   // multiply stage: registered after the product
   logic                 pv_ff;
   meta_type             pm_ff;
   logic signed [NW-1:0] pn_ff [3];
   logic signed [W+1:0]  pov_ff;
   logic [PW-1:0]        pp_ff [3];
   logic                 pneg_ff [3];
   logic [NW-1:0]        an [3];
   logic [W+1:0]         as_c;
   always_comb begin
      as_c = s_c[W+1] ? (W+2)'(-s_c) : (W+2)'(s_c);
      for (int k = 0; k < 3; k++) an[k] = n_c[k][NW-1] ? NW'(-n_c[k]) : NW'(n_c[k]);
   end
   always_ff @(posedge clock) begin
      if (reset) pv_ff <= 1'b0;
      else if (adv) pv_ff <= v_ff[LD];
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         pm_ff <= md; pov_ff <= ov_c;
         for (int k = 0; k < 3; k++) begin
            pn_ff[k]   <= n_c[k];
            pp_ff[k]   <= PW'(an[k] * as_c);
            pneg_ff[k] <= n_c[k][NW-1] ^ s_c[W+1];
         end
      end
   end

   // final assembly with rounding and saturation
   localparam logic signed [W+2:0] SMAX = (W+3)'((64'(1) << (W-1)) - 1);
   localparam logic signed [W+2:0] SMIN = -SMAX - 1;
   function automatic logic [W-1:0] satw(input logic signed [W+2:0] v);
      if (v > SMAX)      satw = SMAX[W-1:0];
      else if (v < SMIN) satw = SMIN[W-1:0];
      else               satw = v[W-1:0];
   endfunction

   logic hit_c, pen_c;
   logic [NW-1:0] nx_c, ny_c, nz_c;
   logic [W-1:0] px_c, py_c, pz_c, ovo_c;
   logic [W-1:0] c2 [3];
   always_comb begin
      logic [PW-1:0] rnd;
      logic signed [W+2:0] sc, sum3;
      logic signed [NW-1:0] nn [3];
      logic [W-1:0] pt [3];
      c2[0] = pm_ff.c2x; c2[1] = pm_ff.c2y; c2[2] = pm_ff.c2z;
      for (int k = 0; k < 3; k++) begin
         rnd  = pp_ff[k] + (PW'(1) << (F-1));
         sc   = (W+3)'(rnd >> F);
         sc   = pneg_ff[k] ? -sc : sc;
         sum3 = (W+3)'($signed(c2[k])) + sc;
         pt[k] = satw(sum3);
         nn[k] = pn_ff[k];
      end
      hit_c = 1'b1; pen_c = pm_ff.first;
      ovo_c = pov_ff[W-1:0];
      unique case (pm_ff.kind)
         KIND_SAME: begin
            nn[0] = '0; nn[1] = -NW'(1 << F); nn[2] = '0;
            pt[0] = pm_ff.c1x; pt[2] = pm_ff.c1z;
            pt[1] = satw((W+3)'($signed(pm_ff.c1y)) + (W+3)'(pm_ff.r1));
            ovo_c = W'(-(W+1)'(pm_ff.r1));
         end
         KIND_GENERAL: ;
         default: begin
            hit_c = 1'b0; pen_c = 1'b0;
         end
      endcase
      if (!pm_ff.first) for (int k = 0; k < 3; k++) nn[k] = -nn[k];
      nx_c = nn[0]; ny_c = nn[1]; nz_c = nn[2];
      px_c = pt[0]; py_c = pt[1]; pz_c = pt[2];
      if (!hit_c) begin
         nx_c = '0; ny_c = '0; nz_c = '0; px_c = '0; py_c = '0; pz_c = '0; ovo_c = '0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (adv) out_valid <= pv_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit <= hit_c; out_pen <= pen_c;
         out_nx <= nx_c; out_ny <= ny_c; out_nz <= nz_c;
         out_px <= px_c; out_py <= py_c; out_pz <= pz_c; out_ov <= ovo_c;
      end
   end

   `SSC_ASSERT(a_back_stall, clock, reset, (out_valid && !out_ready) |=> (out_valid && $stable(out_px)), "back lost a stalled word")
   `SSC_ASSERT(a_back_miss, clock, reset, (out_valid && !out_hit) |-> (out_ov == '0 && !out_pen), "miss word not cleared")
endmodule
`default_nettype wire

// File: sim/sphere_sphere_contact_checker.sv
// Contact checker: watches both channels, predicts each contact word and compares
`timescale 1ns / 1ps
`default_nettype none
module sphere_sphere_contact_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [255:0] req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [183:0] rsp_tdata,
   input  wire logic [1:0]   rsp_tuser,
   output int                fail_count,
   output int                pending_count,
   output int                hit_count,
   output int                word_count
);
   localparam int CW = 32;
   localparam int FB = 16;
   localparam int NW = FB + 2;

   typedef struct packed {
      logic                 hit;
      logic signed [NW-1:0] nx, ny, nz;
      logic signed [CW-1:0] px, py, pz;
      logic signed [CW-1:0] ovl;
      logic                 pen;
   } contact_type;

   contact_type contact_q[$];

   // Clamp to the signed coordinate range
   function automatic logic signed [CW-1:0] clamp_coord(input logic signed [127:0] v);
      if (v > 128'sh7fffffff) return 32'sh7fffffff;
      if (v < -128'sh80000000) return 32'sh80000000;
      return v[CW-1:0];
   endfunction

   // Floor square root of a wide unsigned value, root below 2^31
   function automatic logic [63:0] floor_root(input logic [127:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = CW - 2; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   // Rounded |d| * 2^FB / root_len, half away from zero
   function automatic logic [63:0] unit_share(input logic [63:0] ad,
                                              input logic [63:0] root_len);
      logic [127:0] num;
      logic [127:0] q;
      logic [127:0] rem;
      num = {64'd0, ad} << FB;
      q = num / root_len;
      rem = num % root_len;
      if ((rem << 1) >= root_len) q++;
      return q[63:0];
   endfunction

   function automatic contact_type predict_contact(input logic [255:0] d,
                                                   input logic first_owns);
      contact_type c;
      logic signed [63:0] c1[3], c2[3], df[3], nn[3], pt[3];
      logic signed [63:0] r1, r2, ov, s, m;
      logic [127:0] d2, prod, mag;
      logic [63:0] root_len, sum, ad;
      logic far;
      c = '0;
      far = 0;
      for (int k = 0; k < 3; k++) begin
         c1[k] = $signed(d[32*k +: 32]);
         c2[k] = $signed(d[126 + 32*k +: 32]);
         df[k] = c1[k] - c2[k];
         if (df[k] >= 64'sh80000000 || df[k] <= -64'sh80000000) far = 1;
      end
      r1 = {34'd0, d[96 +: 30]};
      r2 = {34'd0, d[222 +: 30]};
      sum = r1 + r2;
      if (far) return c;
      d2 = 0;
      for (int k = 0; k < 3; k++) begin
         ad = df[k] < 0 ? -df[k] : df[k];
         d2 += {64'd0, ad} * {64'd0, ad};
      end
      if (d2 == 0) begin
         nn[0] = 0; nn[1] = -(64'sd1 <<< FB); nn[2] = 0;
         pt[0] = c1[0]; pt[1] = clamp_coord(c1[1] + r1); pt[2] = c1[2];
         ov = -r1;
      end else begin
         if ({64'd0, sum} * {64'd0, sum} <= d2) return c;
         root_len = floor_root(d2);
         ov = $signed(root_len) - $signed(sum);
         s = r2 + ov;
         for (int k = 0; k < 3; k++) begin
            ad = df[k] < 0 ? -df[k] : df[k];
            m = unit_share(ad, root_len);
            nn[k] = df[k] < 0 ? -m : m;
            prod = {64'd0, (nn[k] < 0 ? -nn[k] : nn[k])} * {64'd0, (s < 0 ? -s : s)};
            mag = (prod + (128'd1 << (FB - 1))) >> FB;
            pt[k] = clamp_coord($signed(c2[k]) +
               (((nn[k] < 0) != (s < 0)) ? -$signed(mag) : $signed(mag)));
         end
      end
      if (!first_owns) for (int k = 0; k < 3; k++) nn[k] = -nn[k];
      c.hit = 1;
      c.nx = nn[0][NW-1:0]; c.ny = nn[1][NW-1:0]; c.nz = nn[2][NW-1:0];
      c.px = pt[0][CW-1:0]; c.py = pt[1][CW-1:0]; c.pz = pt[2][CW-1:0];
      c.ovl = ov[CW-1:0];
      c.pen = first_owns;
      return c;
   endfunction

   assign pending_count = contact_q.size();

   // Predict on accepted pairs, compare accepted contact words
   always @(posedge clock) begin
      contact_type want;
      contact_type got;
      if (reset) begin
         fail_count <= 0;
         hit_count  <= 0;
         word_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            contact_q.push_back(predict_contact(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tuser[0];
            got.pen = rsp_tuser[1];
            {got.ovl, got.pz, got.py, got.px, got.nz, got.ny, got.nx} = rsp_tdata[181:0];
            word_count <= word_count + 1;
            if (contact_q.size() == 0) begin
               $error("contact word with no pair pending");
               fail_count <= fail_count + 1;
            end else begin
               want = contact_q.pop_front();
               if (got.hit) hit_count <= hit_count + 1;
               if (got != want) begin
                  fail_count <= fail_count + 1;
                  if (got.hit != want.hit) $error("hit exp %0d got %0d", want.hit, got.hit);
                  if (got.nx != want.nx) $error("normal_x exp %0d got %0d", want.nx, got.nx);
                  if (got.ny != want.ny) $error("normal_y exp %0d got %0d", want.ny, got.ny);
                  if (got.nz != want.nz) $error("normal_z exp %0d got %0d", want.nz, got.nz);
                  if (got.px != want.px) $error("point_x exp %0d got %0d", want.px, got.px);
                  if (got.py != want.py) $error("point_y exp %0d got %0d", want.py, got.py);
                  if (got.pz != want.pz) $error("point_z exp %0d got %0d", want.pz, got.pz);
                  if (got.ovl != want.ovl) $error("overlap exp %0d got %0d", want.ovl, got.ovl);
                  if (got.pen != want.pen)
                     $error("penetrates_other exp %0d got %0d", want.pen, got.pen);
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

// File: sim/sphere_sphere_contact_test.sv
// Testbench top: drives sphere pairs into the contact block and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module sphere_sphere_contact_test;
   localparam int RANDOM_PAIRS = 830;
   localparam int CALM_TAIL    = 120;
   localparam int STALL_LIMIT  = 2000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count, pending_count, hit_count, word_count;
   int           idle_count;
   int           pairs_sent;
   logic         calm;
   logic         timed_out;

   sphere_sphere_contact u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   sphere_sphere_contact_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .fail_count(fail_count), .pending_count(pending_count),
      .hit_count(hit_count), .word_count(word_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Throttle the result side in random bursts, none in the calm tail
   initial begin
      int n;
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
   end

   assign timed_out = idle_count >= STALL_LIMIT;

   initial begin
      wait (timed_out);
      $display("sphere_sphere_contact_test NOT OK");
      $finish;
   end

   // Offer one pair and hold it until taken, maybe with a gap first
   task automatic send_pair(input logic signed [31:0] c1[3], input logic [29:0] r1,
                            input logic signed [31:0] c2[3], input logic [29:0] r2,
                            input logic owner);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {4'b0000, r2, c2[2], c2[1], c2[0], r1, c1[2], c1[1], c1[0]};
      req_tuser  <= owner;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pairs_sent++;
   endtask

   function automatic logic signed [31:0] any_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
         default: return $signed($urandom_range(0, 'h1ffff)) - 'sh10000;
      endcase
   endfunction

   initial begin
      logic signed [31:0] a[3];
      logic signed [31:0] b[3];
      logic [29:0] ra, rb;
      int span;
      calm = 0;
      pairs_sent = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: coincident, extremes, far apart, zero radii, saturation
      a = '{0, 0, 0}; b = '{0, 0, 0};
      send_pair(a, 30'h10000, b, 30'h10000, 1'b1);
      send_pair(a, 30'h10000, b, 30'h10000, 1'b0);
      a = '{32'sh10, 32'sh7fffff00, -32'sh5}; b = a;
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b1);
      a = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      b = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b1);
      send_pair(b, 30'h3fffffff, a, 30'h3fffffff, 1'b0);
      a = '{32'sh3fffffff, 0, 0}; b = '{-32'sh3fffffff, 0, 0};
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b1);
      a = '{32'sh10000, 0, 0}; b = '{0, 0, 0};
      send_pair(a, 30'h0, b, 30'h0, 1'b1);
      send_pair(a, 30'h8000, b, 30'h8000, 1'b1);
      send_pair(a, 30'h8001, b, 30'h8000, 1'b0);
      a = '{32'sh10000, 32'sh10000, 32'sh10000}; b = '{0, 0, 0};
      send_pair(a, 30'h20000, b, 30'h3fffffff, 1'b1);
      send_pair(b, 30'h3fffffff, a, 30'h1, 1'b0);
      a = '{32'sh7fff0000, 32'sh7fff0000, 0}; b = '{32'sh7ff00000, 32'sh7ff00000, 0};
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b1);
      a = '{-32'sh7fff0000, 0, -32'sh7fff0000}; b = '{-32'sh7ff00000, 0, -32'sh7ff00000};
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b0);
      a = '{1, 0, 0}; b = '{0, 0, 0};
      send_pair(a, 30'h1, b, 30'h1, 1'b1);
      a = '{32'sh7fffffff, 0, 0}; b = '{0, 0, 0};
      send_pair(a, 30'h3fffffff, b, 30'h3fffffff, 1'b1);

      // Random pairs, mostly close enough to touch
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == RANDOM_PAIRS - CALM_TAIL) calm = 1;
         span = $urandom_range(4, 31);
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 7) == 0) begin
               a[k] = any_coord();
               b[k] = any_coord();
            end else begin
               a[k] = $urandom;
               b[k] = a[k] + ($signed($urandom) >>> (32 - span));
               if ($urandom_range(0, 9) == 0) b[k] = a[k];
            end
         end
         ra = 30'($urandom);
         rb = 30'($urandom);
         if ($urandom_range(0, 1)) begin
            ra = ra >> (30 - span);
            rb = rb >> (30 - span);
         end
         send_pair(a, ra, b, rb, 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 0;
      calm = 1;

      // Drain, then allow the pipeline latency to pass
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Sent %0d sphere pairs; %0d contact words checked, %0d of them hits.",
               pairs_sent, word_count, hit_count);
      if (fail_count == 0)
         $display("sphere_sphere_contact_test OK");
      else
         $display("sphere_sphere_contact_test NOT OK");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/ssc_pkg.sv
rtl/core/ssc_front.sv
rtl/core/ssc_queue.sv
rtl/core/ssc_back.sv
rtl/core/sphere_sphere_contact.sv
sim/sphere_sphere_contact_checker.sv
sim/sphere_sphere_contact_test.sv
